// File: rtl/fixed_width_dictionary_unpacker_unit_assert.svh
// Assertion helpers for the dictionary unpacker.
// Every property is clocked on the rising edge and is switched off while reset is held low.
`ifndef FIXED_WIDTH_DICTIONARY_UNPACKER_UNIT_ASSERT_SVH
`define FIXED_WIDTH_DICTIONARY_UNPACKER_UNIT_ASSERT_SVH

// The consequent is checked in the same cycle as the antecedent.
`define FWDU_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define FWDU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fwdu_pkg.sv
package fwdu_pkg;

    localparam int SYMBOL_W          = 8;
    localparam int TABLE_DEPTH_DEF   = 256;
    localparam int LENGTH_BYTES_DEF  = 4;

    // Decoder phases.
    typedef enum logic [2:0] {
        PH_LEN   = 3'd0,
        PH_COUNT = 3'd1,
        PH_WIDTH = 3'd2,
        PH_TABLE = 3'd3,
        PH_DATA  = 3'd4
    } phase_t;

endpackage

// File: rtl/fwdu_ram.sv
module fwdu_ram
    import fwdu_pkg::*;
#(
    parameter int DATA_W = SYMBOL_W,
    parameter int DEPTH  = TABLE_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/fixed_width_dictionary_unpacker_unit.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_data_byte (8)
// m_        out        m_valid / m_ready  m_symbol (8), m_bad_code, m_end_of_message,
//                                         m_last_in_run
//
// A table or data byte goes through the field shifter one bit per cycle while no waiting
// lookup stalls it, so up to eight symbols leave per data byte at one per cycle.
// A symbol passes from its last code bit through the synchronous code memory read, held
// in the lookup stage, and then the output register, where a low m_ready can hold it.
// Reset is synchronous and active low; the entry valid flags are flip-flops, cleared at
// reset and on the first length byte of every header, so no clearing pass is needed.
// When m_ready is low the lookup stage and then the bit shifter stall; header and table
// bytes keep flowing only while no lookup waits.

`include "fixed_width_dictionary_unpacker_unit_assert.svh"

module fixed_width_dictionary_unpacker_unit
    import fwdu_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int LENGTH_BYTES = LENGTH_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_symbol,
    output logic       m_bad_code,
    output logic       m_end_of_message,
    output logic       m_last_in_run
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // Decoder state.
    phase_t            phase_reg, phase_next;
    logic [2:0]        hdr_cnt_reg, hdr_cnt_next;
    logic [30:0]       sym_left_reg, sym_left_next;
    logic [8:0]        ent_left_reg, ent_left_next;
    logic [2:0]        wm1_reg, wm1_next;
    logic [15:0]       acc_reg, acc_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              top_bit_reg, top_bit_next;
    logic [TABLE_DEPTH-1:0] valid_reg;

    // Input byte under work.
    logic [7:0]        byte_reg;
    logic [2:0]        bit_idx_reg;
    logic              busy_reg;

    // Lookup stage, waiting on the memory read.
    logic              pend_v_reg;
    logic              pend_ok_reg;
    logic              pend_eom_reg;
    logic              pend_last_reg;

    // Output register.
    logic              m_valid_reg;
    logic [7:0]        m_symbol_reg;
    logic              m_bad_reg;
    logic              m_eom_reg;
    logic              m_last_reg;

    // Bit datapath.
    logic              cur_bit;
    logic [15:0]       acc_shift;
    logic [4:0]        cnt_inc;
    logic [3:0]        cw;
    logic [7:0]        code_mask;
    logic [7:0]        code;
    logic [7:0]        entry_sym;
    logic              code_in_range;
    logic              entry_done;
    logic              code_done;
    logic [8:0]        ent_dec;
    logic [30:0]       sym_dec;
    logic [30:0]       len_shift;
    logic              len_flag;

    // Control.
    logic              out_free;
    logic              pend_adv;
    logic              step;
    logic              emit;
    logic              tbl_we;
    logic              brk;
    logic              finish;
    logic              clear_valid;
    logic              lookup_ok;
    logic              lookup_eom;
    logic              lookup_last;
    logic [7:0]        ram_rdata;

    // The output register frees when empty or taken; the lookup stage moves whenever the
    // output register can take it, and the shifter steps only when the lookup slot is free or moving on.
    assign out_free = !m_valid_reg || m_ready;
    assign pend_adv = pend_v_reg && out_free;
    assign step     = busy_reg && (!pend_v_reg || out_free);

    assign cur_bit   = byte_reg[bit_idx_reg];
    assign acc_shift = {acc_reg[14:0], cur_bit};
    assign cnt_inc   = cnt_reg + 5'd1;
    assign cw        = {1'b0, wm1_reg} + 4'd1;
    assign code_mask = 8'((9'd1 << cw) - 9'd1);
    assign code      = acc_shift[7:0] & code_mask;
    assign entry_sym = 8'(acc_shift >> cw);
    assign code_in_range = {1'b0, code} < 9'(TABLE_DEPTH);
    assign entry_done = cnt_inc >= (5'd8 + 5'(cw));
    assign code_done  = cnt_inc >= 5'(cw);
    assign ent_dec   = ent_left_reg - 9'd1;
    assign sym_dec   = sym_left_reg - 31'd1;

    // The count accumulates big-endian; a set top bit of a four-byte count forces zero.
    assign len_shift = {((hdr_cnt_reg == 3'd0) ? 23'd0 : sym_left_reg[22:0]), byte_reg};
    assign len_flag  = (hdr_cnt_reg == 3'd0)
                       ? ((LENGTH_BYTES == 4) && byte_reg[7]) : top_bit_reg;

    // Next state of the decoder.
    always_comb begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        sym_left_next = sym_left_reg;
        ent_left_next = ent_left_reg;
        wm1_next      = wm1_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        top_bit_next  = top_bit_reg;
        if (step) begin
            case (phase_reg)
                PH_LEN: begin
                    top_bit_next  = len_flag;
                    sym_left_next = len_shift;
                    hdr_cnt_next  = hdr_cnt_reg + 3'd1;
                    if (hdr_cnt_next >= 3'(LENGTH_BYTES)) begin
                        if (len_flag) begin
                            sym_left_next = '0;
                        end
                        hdr_cnt_next = '0;
                        phase_next   = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    ent_left_next = (byte_reg == 8'd0) ? 9'd256 : {1'b0, byte_reg};
                    phase_next    = PH_WIDTH;
                end
                PH_WIDTH: begin
                    wm1_next   = (byte_reg > 8'd7) ? 3'd7 : byte_reg[2:0];
                    acc_next   = '0;
                    cnt_next   = '0;
                    phase_next = PH_TABLE;
                end
                PH_TABLE: begin
                    acc_next = acc_shift;
                    cnt_next = cnt_inc;
                    if (entry_done) begin
                        acc_next      = '0;
                        cnt_next      = '0;
                        ent_left_next = ent_dec;
                        if (ent_dec == 9'd0) begin
                            phase_next = (sym_left_reg == 31'd0) ? PH_LEN : PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    acc_next = acc_shift;
                    cnt_next = cnt_inc;
                    if (code_done) begin
                        acc_next      = '0;
                        cnt_next      = '0;
                        sym_left_next = sym_dec;
                        if (sym_dec == 31'd0) begin
                            phase_next = PH_LEN;
                        end
                    end
                end
                default: begin
                    phase_next = PH_LEN;
                end
            endcase
        end
    end

    // Decoder outputs: table writes, lookups and the end of the current byte.
    always_comb begin
        emit        = 1'b0;
        tbl_we      = 1'b0;
        brk         = 1'b0;
        clear_valid = 1'b0;
        finish      = 1'b0;
        if (step) begin
            case (phase_reg)
                PH_LEN: begin
                    clear_valid = (hdr_cnt_reg == 3'd0);
                    finish      = 1'b1;
                end
                PH_TABLE: begin
                    tbl_we = entry_done && code_in_range;
                    brk    = entry_done && (ent_dec == 9'd0) && (sym_left_reg == 31'd0);
                    finish = brk || (bit_idx_reg == 3'd0);
                end
                PH_DATA: begin
                    emit   = code_done;
                    brk    = code_done && (sym_dec == 31'd0);
                    finish = brk || (bit_idx_reg == 3'd0);
                end
                default: begin
                    finish = 1'b1;
                end
            endcase
        end
    end

    assign lookup_ok   = code_in_range && valid_reg[code[AW-1:0]];
    assign lookup_eom  = (sym_dec == 31'd0);
    // Another code still fits in this byte only if the bits left cover a whole code.
    assign lookup_last = lookup_eom || ({1'b0, bit_idx_reg} < cw);

    assign s_ready = !busy_reg || finish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_LEN;
            hdr_cnt_reg  <= '0;
            sym_left_reg <= '0;
            ent_left_reg <= '0;
            wm1_reg      <= '0;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            top_bit_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            sym_left_reg <= sym_left_next;
            ent_left_reg <= ent_left_next;
            wm1_reg      <= wm1_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            top_bit_reg  <= top_bit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clear_valid) begin
            valid_reg <= '0;
        end else if (tbl_we) begin
            valid_reg[code[AW-1:0]] <= 1'b1;
        end
    end

    // Byte holding register with its bit pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            bit_idx_reg <= '0;
        end else if (s_valid && s_ready) begin
            busy_reg    <= 1'b1;
            bit_idx_reg <= 3'd7;
        end else if (finish) begin
            busy_reg    <= 1'b0;
        end else if (step) begin
            bit_idx_reg <= bit_idx_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_data_byte;
        end
    end

    // Code-to-symbol memory. A table write lands in an earlier cycle than any read of
    // the same entry, so the registered read always sees it.
    fwdu_ram #(
        .DATA_W (SYMBOL_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_code_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (code[AW-1:0]),
        .wdata (entry_sym),
        .re    (emit),
        .raddr (code[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Lookup stage flags travel alongside the memory read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_v_reg <= 1'b0;
        end else if (emit) begin
            pend_v_reg <= 1'b1;
        end else if (pend_adv) begin
            pend_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            pend_ok_reg   <= lookup_ok;
            pend_eom_reg  <= lookup_eom;
            pend_last_reg <= lookup_last;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pend_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_adv) begin
            m_symbol_reg <= pend_ok_reg ? ram_rdata : 8'd0;
            m_bad_reg    <= !pend_ok_reg;
            m_eom_reg    <= pend_eom_reg;
            m_last_reg   <= pend_last_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_symbol         = m_symbol_reg;
    assign m_bad_code       = m_bad_reg;
    assign m_end_of_message = m_eom_reg;
    assign m_last_in_run    = m_last_reg;

    // The last symbol of a message always closes the run of its byte.
    `FWDU_ASSERT_SAME(a_eom_closes_run, aclk, aresetn, m_valid && m_end_of_message, m_last_in_run, "end of message without last_in_run")
    // An unknown code must come out as symbol zero.
    `FWDU_ASSERT_SAME(a_bad_code_zero, aclk, aresetn, m_valid && m_bad_code, m_symbol == 8'd0, "bad code with nonzero symbol")
    // A waiting lookup keeps its read data until the output register takes it.
    `FWDU_ASSERT_NEXT(a_lookup_hold, aclk, aresetn, pend_v_reg && !out_free, pend_v_reg && $stable(ram_rdata), "pending lookup lost its read data")

endmodule
